// ===== rtl/hltfp_pkg.sv =====
package hltfp_pkg;

	// Frame limits and store geometry.
	localparam int MAX_PAYLOAD = 64;
	localparam int STORE_DEPTH = 64;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);
	localparam int CNT_W       = 7;
	localparam int APB_ADDR_W  = 4;
	localparam int APB_DATA_W  = 32;

	// Register reset values.
	localparam logic [7:0] HEAD_RST = 8'h50;
	localparam logic [7:0] TAIL_RST = 8'h43;
	localparam logic [7:0] BIAS_RST = 8'h30;

	// Register indexes on the configuration port.
	typedef enum logic [1:0] {
		REG_HEAD = 2'd0,
		REG_TAIL = 2'd1,
		REG_BIAS = 2'd2
	} reg_idx_t;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_EMPTY   = 2'd1,
		KIND_REJECT  = 2'd2
	} kind_t;

	// Parser states.
	typedef enum logic [1:0] {
		ST_HUNT,
		ST_LEN,
		ST_DATA,
		ST_EMIT
	} state_t;

	// Configuration registers as seen by the parser.
	typedef struct packed {
		logic [7:0] head_byte;
		logic [7:0] tail_byte;
		logic [7:0] length_bias;
	} cfg_t;

	// Requests from the parser to the result stage.
	typedef struct packed {
		logic       dir_valid;
		kind_t      dir_kind;
		logic [7:0] dir_length;
		logic       rd_issue;
		logic       rd_last;
		logic [7:0] rd_length;
	} res_req_t;

	// Status from the result stage back to the parser.
	typedef struct packed {
		logic can_issue;
		logic busy;
	} res_stat_t;

endpackage

// ===== rtl/head_length_tail_frame_parser.sv =====
// Head-length-tail frame parser.
// The rx channel (rx_valid, rx_stall, rx_byte) takes one received byte per
// transaction. The block hunts for a head byte, decodes the next byte minus
// the length bias as the payload length, stores that many payload bytes in a
// 64-entry memory and checks the following byte against the tail byte.
// The res channel (res_valid, res_stall, kind, payload_byte, frame_length,
// last) returns results: the stored payload as a run closed by last, one
// empty-frame result, or one reject result. A length above 64 rejects at once.
// Ordinary bytes are taken one per cycle outside a payload run and give no
// result. A direct result appears in the cycle after its byte; a payload run
// passes the state, store read and result registers, then gives one byte per
// cycle unless stalled, set by the store's single read port. rx_stall also
// rises on a length or tail byte while the read stage or a stalled result
// register is full. A stalled result holds; the read stage waits behind it.
// Reset clears the control state and loads the default registers; it needs
// no clearing pass, since every payload entry is written before it is read.
// Registers are written on the APB port at byte addresses 0, 4 and 8.
module head_length_tail_frame_parser
	import hltfp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  rx_valid,
	output logic                  rx_stall,
	input  logic [7:0]            rx_byte,
	output logic                  res_valid,
	input  logic                  res_stall,
	output logic [1:0]            kind,
	output logic [7:0]            payload_byte,
	output logic [7:0]            frame_length,
	output logic                  last
);

	cfg_t                cfg;
	res_req_t            req;
	res_stat_t           stat;
	logic                ram_we;
	logic [STORE_AW-1:0] ram_waddr;
	logic [7:0]          ram_wdata;
	logic                ram_re;
	logic [STORE_AW-1:0] ram_raddr;
	logic [7:0]          ram_rdata;

	// Configuration registers.
	hltfp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Frame parser and emission sequencer.
	hltfp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.rx_valid  (rx_valid),
		.rx_stall  (rx_stall),
		.rx_byte   (rx_byte),
		.stat      (stat),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.req       (req)
	);

	// Payload store.
	hltfp_ram #(
		.WIDTH (8),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Read stage and result register.
	hltfp_outq u_outq (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.ram_rdata    (ram_rdata),
		.stat         (stat),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.kind         (kind),
		.payload_byte (payload_byte),
		.frame_length (frame_length),
		.last         (last)
	);

endmodule

// ===== rtl/hltfp_ram.sv =====
module hltfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port; read data holds when not enabled.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/hltfp_regs.sv =====
module hltfp_regs
	import hltfp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	logic       wr_en;
	reg_idx_t   idx;
	logic [7:0] head_q;
	logic [7:0] tail_q;
	logic [7:0] bias_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[3:2]);

	// Register writes; an address beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= HEAD_RST;
			tail_q <= TAIL_RST;
			bias_q <= BIAS_RST;
		end else if (wr_en) begin
			case (idx)
				REG_HEAD: head_q <= pwdata[7:0];
				REG_TAIL: tail_q <= pwdata[7:0];
				REG_BIAS: bias_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read back.
	always_comb begin
		case (idx)
			REG_HEAD: prdata = {{(APB_DATA_W-8){1'b0}}, head_q};
			REG_TAIL: prdata = {{(APB_DATA_W-8){1'b0}}, tail_q};
			REG_BIAS: prdata = {{(APB_DATA_W-8){1'b0}}, bias_q};
			default:  prdata = '0;
		endcase
	end

	assign cfg.head_byte   = head_q;
	assign cfg.tail_byte   = tail_q;
	assign cfg.length_bias = bias_q;

endmodule

// ===== rtl/hltfp_ctrl.sv =====
module hltfp_ctrl
	import hltfp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                rx_valid,
	output logic                rx_stall,
	input  logic [7:0]          rx_byte,
	input  res_stat_t           stat,
	output logic                ram_we,
	output logic [STORE_AW-1:0] ram_waddr,
	output logic [7:0]          ram_wdata,
	output logic                ram_re,
	output logic [STORE_AW-1:0] ram_raddr,
	output res_req_t            req
);

	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_d;
	logic [CNT_W-1:0] len_q;
	logic [CNT_W-1:0] len_d;
	logic             accept;
	logic [7:0]       len8;
	logic             too_long;
	logic             at_tail;
	logic             tail_ok;
	logic             emit_last;

	assign len8      = rx_byte - cfg.length_bias;
	assign too_long  = len8 > 8'(MAX_PAYLOAD);
	assign at_tail   = cnt_q == len_q;
	assign tail_ok   = rx_byte == cfg.tail_byte;
	assign emit_last = cnt_q == (len_q - CNT_W'(1));

	// Input stall: all bytes in ST_EMIT, else bytes that may give a result while busy.
	always_comb begin
		case (state_q)
			ST_HUNT: rx_stall = 1'b0;
			ST_LEN:  rx_stall = stat.busy;
			ST_DATA: rx_stall = at_tail && stat.busy;
			ST_EMIT: rx_stall = 1'b1;
			default: rx_stall = 1'b1;
		endcase
	end

	assign accept = rx_valid && !rx_stall;

	// Next state and counters.
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		len_d   = len_q;
		case (state_q)
			ST_HUNT: begin
				if (accept && rx_byte == cfg.head_byte) begin
					state_d = ST_LEN;
				end
			end
			ST_LEN: begin
				if (accept) begin
					cnt_d = '0;
					if (too_long) begin
						state_d = ST_HUNT;
						len_d   = '0;
					end else begin
						state_d = ST_DATA;
						len_d   = len8[CNT_W-1:0];
					end
				end
			end
			ST_DATA: begin
				if (accept) begin
					if (!at_tail) begin
						cnt_d = cnt_q + CNT_W'(1);
					end else if (tail_ok && len_q != '0) begin
						state_d = ST_EMIT;
						cnt_d   = '0;
					end else begin
						state_d = ST_HUNT;
					end
				end
			end
			ST_EMIT: begin
				if (stat.can_issue) begin
					cnt_d = cnt_q + CNT_W'(1);
					if (emit_last) begin
						state_d = ST_HUNT;
					end
				end
			end
			default: state_d = ST_HUNT;
		endcase
	end

	// Outputs: store writes, store reads and result requests.
	always_comb begin
		ram_we         = 1'b0;
		ram_waddr      = cnt_q[STORE_AW-1:0];
		ram_wdata      = rx_byte;
		ram_re         = 1'b0;
		ram_raddr      = cnt_q[STORE_AW-1:0];
		req.dir_valid  = 1'b0;
		req.dir_kind   = KIND_REJECT;
		req.dir_length = 8'({1'b0, len_q});
		req.rd_issue   = 1'b0;
		req.rd_last    = emit_last;
		req.rd_length  = 8'({1'b0, len_q});
		case (state_q)
			ST_LEN: begin
				if (accept && too_long) begin
					req.dir_valid  = 1'b1;
					req.dir_length = len8;
				end
			end
			ST_DATA: begin
				if (accept && !at_tail) begin
					ram_we = 1'b1;
				end
				if (accept && at_tail) begin
					if (!tail_ok) begin
						req.dir_valid = 1'b1;
					end else if (len_q == '0) begin
						req.dir_valid  = 1'b1;
						req.dir_kind   = KIND_EMPTY;
						req.dir_length = '0;
					end
				end
			end
			ST_EMIT: begin
				if (stat.can_issue) begin
					ram_re       = 1'b1;
					req.rd_issue = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
			cnt_q   <= '0;
			len_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			len_q   <= len_d;
		end
	end

endmodule

// ===== rtl/hltfp_outq.sv =====
module hltfp_outq
	import hltfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  res_req_t   req,
	input  logic [7:0] ram_rdata,
	output res_stat_t  stat,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [1:0] kind,
	output logic [7:0] payload_byte,
	output logic [7:0] frame_length,
	output logic       last
);

	logic       valid_s1;
	logic       last_s1;
	logic [7:0] len_s1;
	logic       out_valid_q;
	kind_t      kind_q;
	logic [7:0] byte_q;
	logic [7:0] len_q;
	logic       last_q;
	logic       out_free;
	logic       s1_move;

	assign out_free       = !out_valid_q || !res_stall;
	assign s1_move        = valid_s1 && out_free;
	assign stat.can_issue = !valid_s1 || s1_move;
	assign stat.busy      = valid_s1 || (out_valid_q && res_stall);

	// Read stage: tracks the payload byte sitting in the store's read register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.rd_issue) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_issue) begin
			last_s1 <= req.rd_last;
			len_s1  <= req.rd_length;
		end
	end

	// Output register: takes a payload byte from the read stage or a direct result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_move || req.dir_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			kind_q <= KIND_PAYLOAD;
			byte_q <= ram_rdata;
			len_q  <= len_s1;
			last_q <= last_s1;
		end else if (out_free && req.dir_valid) begin
			kind_q <= req.dir_kind;
			byte_q <= '0;
			len_q  <= req.dir_length;
			last_q <= 1'b1;
		end
	end

	assign res_valid    = out_valid_q;
	assign kind         = kind_q;
	assign payload_byte = byte_q;
	assign frame_length = len_q;
	assign last         = last_q;

endmodule

// ===== verif/head_length_tail_frame_parser_test.sv =====
`timescale 1ns / 100ps

module head_length_tail_frame_parser_test;
	import hltfp_pkg::*;

	localparam int CYCLE_LIMIT  = 4000000;
	localparam int DRAIN_CYCLES = 8;
	localparam int LONG_HOLD    = 400;

	// Address past the last register; writes there must have no effect.
	localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = 4'd12;

	// One result transaction as the parser should deliver it.
	typedef struct packed {
		kind_t      kind;
		logic [7:0] payload_byte;
		logic [7:0] frame_length;
		logic       last;
	} frame_result_t;

	// Tracks the frame state of the parser and holds the results it owes.
	class frame_checker;
		logic [7:0]    head_byte;
		logic [7:0]    tail_byte;
		logic [7:0]    length_bias;
		logic [6:0]    position;
		logic [6:0]    payload_length;
		logic [7:0]    payload_store [STORE_DEPTH];
		frame_result_t awaited_results [$];
		int            fails;

		function new();
			head_byte      = HEAD_RST;
			tail_byte      = TAIL_RST;
			length_bias    = BIAS_RST;
			position       = '0;
			payload_length = '0;
			fails          = 0;
			foreach (payload_store[i])
				payload_store[i] = '0;
		endfunction

		function void write_register(reg_idx_t idx, logic [7:0] value);
			case (idx)
				REG_HEAD: head_byte   = value;
				REG_TAIL: tail_byte   = value;
				REG_BIAS: length_bias = value;
				default: ;
			endcase
		endfunction

		function void owe_result(kind_t k, logic [7:0] pb, logic [7:0] fl, logic l);
			frame_result_t r;
			r.kind         = k;
			r.payload_byte = pb;
			r.frame_length = fl;
			r.last         = l;
			awaited_results.push_back(r);
		endfunction

		// Advances the frame state by one accepted byte.
		function void take_rx_byte(logic [7:0] b);
			logic [7:0] len;
			int         n;
			if (position == 0) begin
				if (b == head_byte)
					position = 7'd1;
				return;
			end
			if (position == 1) begin
				len = b - length_bias;
				if (int'(len) > MAX_PAYLOAD) begin
					position       = 7'd0;
					payload_length = 7'd0;
					owe_result(KIND_REJECT, 8'h00, len, 1'b1);
					return;
				end
				payload_length = len[6:0];
				position       = 7'd2;
				return;
			end
			if (int'(position) < int'(payload_length) + 2) begin
				payload_store[(int'(position) - 2) % STORE_DEPTH] = b;
				position = position + 7'd1;
				return;
			end
			// The byte at the tail position closes the frame either way.
			position = 7'd0;
			if (b != tail_byte) begin
				owe_result(KIND_REJECT, 8'h00, {1'b0, payload_length}, 1'b1);
			end else if (payload_length == 0) begin
				owe_result(KIND_EMPTY, 8'h00, 8'h00, 1'b1);
			end else begin
				n = (int'(payload_length) > STORE_DEPTH) ? STORE_DEPTH : int'(payload_length);
				for (int k = 0; k < n; k++)
					owe_result(KIND_PAYLOAD, payload_store[k], {1'b0, payload_length},
						k == n - 1);
			end
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
				fails++;
			end
		endfunction

		function void check_result(logic [1:0] k, logic [7:0] pb, logic [7:0] fl, logic l);
			frame_result_t want;
			if (awaited_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got kind %0d byte %h length %h last %b",
					$time, k, pb, fl, l);
				fails++;
				return;
			end
			want = awaited_results.pop_front();
			compare_field("kind", {6'd0, want.kind}, {6'd0, k});
			compare_field("payload_byte", want.payload_byte, pb);
			compare_field("frame_length", want.frame_length, fl);
			compare_field("last", {7'd0, want.last}, {7'd0, l});
		endfunction

		function int pending();
			return awaited_results.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  rx_valid;
	logic                  rx_stall;
	logic [7:0]            rx_byte;
	logic                  res_valid;
	logic                  res_stall;
	logic [1:0]            kind;
	logic [7:0]            payload_byte;
	logic [7:0]            frame_length;
	logic                  last;

	frame_checker chk = new();
	int           cycle_count = 0;
	int           tx_calm_left = 0;
	logic         hold_request = 1'b0;

	head_length_tail_frame_parser i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.rx_valid     (rx_valid),
		.rx_stall     (rx_stall),
		.rx_byte      (rx_byte),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.kind         (kind),
		.payload_byte (payload_byte),
		.frame_length (frame_length),
		.last         (last)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("head_length_tail_frame_parser test failed");
			$finish;
		end
	end

	// Check every result transaction as it is taken.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			chk.check_result(kind, payload_byte, frame_length, last);
	end

	// Result side backpressure: calm stretches, short and long stalls, and one
	// long hold-off on request so that the parser fills up.
	initial begin
		int stall_left;
		int calm_left;
		int r;
		res_stall  = 1'b0;
		stall_left = 0;
		calm_left  = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				res_stall = 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				hold_request = 1'b0;
				res_stall    = 1'b0;
			end else if (stall_left > 0) begin
				res_stall = 1'b1;
				stall_left--;
			end else if (calm_left > 0) begin
				res_stall = 1'b0;
				calm_left--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 5)
					calm_left = $urandom_range(20, 80);
				else if (r < 8)
					stall_left = $urandom_range(10, 40);
				else if (r < 35)
					stall_left = $urandom_range(1, 3);
				res_stall = 1'b0;
			end
		end
	end

	function automatic logic [APB_ADDR_W-1:0] reg_addr(reg_idx_t idx);
		return {idx, 2'b00};
	endfunction

	task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
		input logic [APB_DATA_W-1:0] data);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = addr;
		pwdata  = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic check_register(input reg_idx_t idx, input logic [7:0] want);
		logic [APB_DATA_W-1:0] got;
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = reg_addr(idx);
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		if (got[7:0] !== want) begin
			$display("%0t: register %s readback mismatch, expected %h, got %h",
				$time, idx.name(), want, got[7:0]);
			chk.fails++;
		end
	endtask

	// Offer one byte, hold it until taken, then maybe leave a gap.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		int r;
		@(negedge clk);
		rx_valid = 1'b1;
		rx_byte  = b;
		do @(posedge clk); while (rx_stall);
		chk.take_rx_byte(b);
		gap = 0;
		if (tx_calm_left > 0) begin
			tx_calm_left--;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 5)
				tx_calm_left = $urandom_range(20, 60);
			else if (r >= 55 && r < 90)
				gap = $urandom_range(1, 3);
			else if (r >= 90)
				gap = $urandom_range(8, 40);
		end
		if (gap > 0) begin
			@(negedge clk);
			rx_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Let every owed result come out, then give the parser time to settle.
	task automatic wait_drained();
		@(negedge clk);
		rx_valid = 1'b0;
		while (chk.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apply_config(input logic [7:0] head, input logic [7:0] tail,
		input logic [7:0] bias);
		logic [7:0] vals [3];
		reg_idx_t   idx;
		vals[0] = head;
		vals[1] = tail;
		vals[2] = bias;
		wait_drained();
		for (int i = 0; i < 3; i++) begin
			idx = reg_idx_t'(i);
			apb_write(reg_addr(idx), {24'd0, vals[i]});
			chk.write_register(idx, vals[i]);
		end
		for (int i = 0; i < 3; i++)
			check_register(reg_idx_t'(i), vals[i]);
	endtask

	// Mostly well-formed frames with random content, some noise, some frames
	// cut short and some with a wrong tail. Noise bytes are not counted.
	task automatic run_random_frames(input int budget);
		int         sent;
		int         len;
		int         cut;
		int         r;
		logic [7:0] b;
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(0, 99) < 8) begin
				repeat ($urandom_range(1, 3)) begin
					b = 8'($urandom);
					send_byte(b);
				end
				continue;
			end
			r = $urandom_range(0, 99);
			if (r < 75)
				len = $urandom_range(0, 8);
			else if (r < 88)
				len = $urandom_range(9, MAX_PAYLOAD - 1);
			else if (r < 93)
				len = MAX_PAYLOAD;
			else
				len = $urandom_range(MAX_PAYLOAD + 1, 255);
			cut = ($urandom_range(0, 99) < 5) ? $urandom_range(0, len) : -1;
			send_byte(chk.head_byte);
			send_byte(chk.length_bias + len[7:0]);
			sent += 2;
			if (len > MAX_PAYLOAD)
				continue;
			for (int k = 0; k < len && k != cut; k++) begin
				b = 8'($urandom);
				send_byte(b);
				sent++;
			end
			if (cut >= 0)
				continue;
			if ($urandom_range(0, 9) == 0)
				b = 8'($urandom);
			else
				b = chk.tail_byte;
			send_byte(b);
			sent++;
		end
	endtask

	// Main sequence.
	initial begin
		logic [7:0] directed [21];
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		rx_valid = 1'b0;
		rx_byte  = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// Noise at both byte extremes, an empty frame, a two-byte frame,
		// a head byte used as payload and as a wrong tail, lengths just
		// above the limit and wrapping below the bias, and a head byte in
		// the tail position of an empty frame.
		directed = '{8'h00, 8'hFF,
			HEAD_RST, BIAS_RST, TAIL_RST,
			HEAD_RST, BIAS_RST + 8'd2, 8'h00, 8'hFF, TAIL_RST,
			HEAD_RST, BIAS_RST + 8'd1, HEAD_RST, HEAD_RST,
			HEAD_RST, BIAS_RST + 8'd65,
			HEAD_RST, BIAS_RST - 8'd1,
			HEAD_RST, BIAS_RST, HEAD_RST};
		foreach (directed[i])
			send_byte(directed[i]);

		// Default registers, with one long hold-off on the result side.
		hold_request = 1'b1;
		run_random_frames(110);

		// Register extremes, then random settings.
		apply_config(8'h00, 8'hFF, 8'h00);
		run_random_frames(75);
		apply_config(8'hFF, 8'h00, 8'hFF);
		run_random_frames(75);
		apply_config(8'($urandom), 8'($urandom), 8'($urandom));
		run_random_frames(75);

		// Back to the defaults; a write past the register list must not
		// disturb them.
		apply_config(HEAD_RST, TAIL_RST, BIAS_RST);
		apb_write(SPARE_ADDR, $urandom);
		run_random_frames(75);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (chk.fails == 0)
			$display("head_length_tail_frame_parser test passed");
		else
			$display("head_length_tail_frame_parser test failed");
		$finish;
	end

endmodule

// ===== head_length_tail_frame_parser.f =====
rtl/hltfp_pkg.sv
rtl/hltfp_ram.sv
rtl/hltfp_regs.sv
rtl/hltfp_ctrl.sv
rtl/hltfp_outq.sv
rtl/head_length_tail_frame_parser.sv
verif/head_length_tail_frame_parser_test.sv
